### src/rcw_pkg.sv
// shared types, constants and codes of the textured wall column renderer
`default_nettype none
package rcw_pkg;

   localparam int TEX_SIZE  = 64;
   localparam int MAX_ROWS  = 1024;
   localparam int MAX_COLS  = 2048;

   localparam int TEX_BITS  = $clog2(TEX_SIZE);
   localparam int TEX_ADDR_BITS = 2 * TEX_BITS;
   localparam int TEX_ENTRIES = TEX_SIZE * TEX_SIZE;
   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int H_BITS    = ROW_BITS + 1;
   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int NUM_BITS  = H_BITS + 16;
   localparam int PA_BITS   = 21;
   localparam int SH_BITS   = 11;
   localparam int SW_BITS   = 12;
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_ROW   = 2'd2;

   localparam logic [1:0] REGION_CEILING = 2'd0;
   localparam logic [1:0] REGION_WALL    = 2'd1;
   localparam logic [1:0] REGION_FLOOR   = 2'd2;

   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_CEILING_COLOR = 2'd2;
   localparam logic [1:0] CSR_FLOOR_COLOR   = 2'd3;

   typedef enum logic [1:0] {
      K_LOAD,
      K_START,
      K_ROW
   } kind_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FRAC,
      B_DIV_H,
      B_DIV_S,
      B_POS,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [11:0]        texel_index;
      logic [31:0]        texel_value;
      logic [10:0]        column;
      logic [31:0]        perp_dist;
      logic               hit_side;
      logic signed [17:0] ray_dir_x;
      logic signed [17:0] ray_dir_y;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
   } item_type;

endpackage
`default_nettype wire

### src/rcw_ram.sv
// generic single write, single registered read memory
`default_nettype none
module rcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### src/rcw_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module rcw_div import rcw_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [31:0]         den,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quo
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [32:0]         rem_sh;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, num_ff[NUM_BITS-1]};
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CNT_BITS'(NUM_BITS);
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

### src/rcw_front.sv
// request intake: decodes the op and queues requests for the back end, dropping unknown ops
`default_nettype none
module rcw_front import rcw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [191:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,
   output logic               q_valid,
   output item_type           q_item,
   input  wire logic          q_pop
);

   item_type                ent_ff [QDEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]      cnt_ff, cnt_in;
   item_type                item;
   logic                    keep;
   logic                    push;

   always_comb begin
      item.kind        = K_LOAD;
      keep             = 1'b1;
      case (req_tuser)
         OP_LOAD:  item.kind = K_LOAD;
         OP_START: item.kind = K_START;
         OP_ROW:   item.kind = K_ROW;
         default:  keep = 1'b0;
      endcase
      item.texel_index = req_tdata[11:0];
      item.texel_value = req_tdata[43:12];
      item.column      = req_tdata[54:44];
      item.perp_dist   = req_tdata[86:55];
      item.hit_side    = req_tdata[87];
      item.ray_dir_x   = req_tdata[105:88];
      item.ray_dir_y   = req_tdata[123:106];
      item.pos_x       = req_tdata[155:124];
      item.pos_y       = req_tdata[187:156];
   end

   assign req_tready = (cnt_ff != (QPTR_BITS+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = ent_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

### src/rcw_back.sv
// column set-up, row emission, texture store and control registers
`default_nettype none
module rcw_back import rcw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire item_type      q_item,
   output logic               q_pop,
   input  wire logic          csr_valid,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [PA_BITS-1:0] rsp_addr,
   output logic [31:0]        rsp_color,
   output logic [1:0]         rsp_region,
   output logic               rsp_last
);

   back_state_type state_ff, state_in;

   logic [SH_BITS-1:0]  sh_ff;
   logic [SW_BITS-1:0]  sw_ff;
   logic [31:0]         ceil_ff, floor_ff;

   item_type            cur_ff, cur_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                active_ff, active_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] sstart_ff, sstart_in;
   logic [ROW_BITS-1:0] send_ff, send_in;
   logic [TEX_BITS-1:0] tcol_ff, tcol_in;
   logic [31:0]         tpos_ff, tpos_in;
   logic [31:0]         tstep_ff, tstep_in;
   logic [31:0]         prod_ff, prod_in;
   logic [NUM_BITS-2:0] offset_ff, offset_in;
   logic                hzero_ff, hzero_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PA_BITS-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [31:0]         rsp_color_ff, rsp_color_in;
   logic [1:0]          rsp_region_ff, rsp_region_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [PA_BITS-1:0]  em_addr_ff, em_addr_in;
   logic [31:0]         em_color_ff, em_color_in;
   logic [1:0]          em_region_ff, em_region_in;
   logic                em_last_ff, em_last_in;

   logic [H_BITS-1:0]   h_eff;
   logic [ROW_BITS-1:0] half_s;
   logic [NUM_BITS-1:0] height;
   logic [NUM_BITS-2:0] half_h;
   logic [NUM_BITS-1:0] end_sum;
   logic [31:0]         frac;
   logic [31:0]         dir32;
   logic [31:0]         pos_sel;
   logic [TEX_BITS-1:0] tx;
   logic                mirror;

   logic                div_start;
   logic [NUM_BITS-1:0] div_num;
   logic [31:0]         div_den;
   logic                div_done;
   logic [NUM_BITS-1:0] div_quo;

   logic                ram_we;
   logic [TEX_ADDR_BITS-1:0] ram_raddr;
   logic [31:0]         ram_rdata;

   logic                last_row;
   logic [ROW_BITS+SW_BITS-1:0] row_mul;

   rcw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   rcw_ram #(.WIDTH(32), .DEPTH(TEX_ENTRIES)) u_tex (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_item.texel_index[TEX_ADDR_BITS-1:0]),
      .wr_data (q_item.texel_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective screen height clamped to [1, MAX_ROWS]
   always_comb begin
      if (sh_ff == '0) begin
         h_eff = H_BITS'(1);
      end else if (32'(sh_ff) > 32'(MAX_ROWS)) begin
         h_eff = H_BITS'(MAX_ROWS);
      end else begin
         h_eff = H_BITS'(sh_ff);
      end
      half_s = ROW_BITS'(h_eff >> 1);
   end

   // wall fraction from the registered distance times direction product
   always_comb begin
      pos_sel = cur_ff.hit_side ? cur_ff.pos_x : cur_ff.pos_y;
      dir32   = cur_ff.hit_side ? 32'(cur_ff.ray_dir_x) : 32'(cur_ff.ray_dir_y);
      frac    = {pos_sel[15:0], 16'b0} + prod_ff;
      mirror  = (!cur_ff.hit_side && cur_ff.ray_dir_x != '0 && !cur_ff.ray_dir_x[17])
             || (cur_ff.hit_side && cur_ff.ray_dir_y[17]);
      tx      = mirror ? ~frac[31 -: TEX_BITS] : frac[31 -: TEX_BITS];
   end

   always_comb begin
      height  = (cur_ff.perp_dist == '0) ? '1 : div_quo;
      half_h  = height[NUM_BITS-1:1];
      end_sum = {1'b0, half_h} + NUM_BITS'(half_s);
   end

   assign last_row = ({1'b0, row_ff} + 1'b1) >= h_eff;
   assign row_mul  = row_ff * sw_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      row_in        = row_ff;
      active_in     = active_ff;
      col_in        = col_ff;
      sstart_in     = sstart_ff;
      send_in       = send_ff;
      tcol_in       = tcol_ff;
      tpos_in       = tpos_ff;
      tstep_in      = tstep_ff;
      prod_in       = prod_ff;
      offset_in     = offset_ff;
      hzero_in      = hzero_ff;
      em_addr_in    = em_addr_ff;
      em_color_in   = em_color_ff;
      em_region_in  = em_region_ff;
      em_last_in    = em_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_region_in = rsp_region_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = {tpos_ff[16 +: TEX_BITS], tcol_ff};
      div_start     = 1'b0;
      div_num       = NUM_BITS'(h_eff) << 16;
      div_den       = cur_ff.perp_dist;

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  K_LOAD: ram_we = 1'b1;
                  K_START: begin
                     cur_in   = q_item;
                     state_in = B_FRAC;
                  end
                  K_ROW: begin
                     if (active_ff) begin
                        em_addr_in = PA_BITS'(row_mul + (ROW_BITS+SW_BITS)'(col_ff));
                        em_last_in = last_row;
                        if (row_ff < sstart_ff) begin
                           em_region_in = REGION_CEILING;
                           em_color_in  = ceil_ff;
                        end else if (row_ff <= send_ff) begin
                           em_region_in = REGION_WALL;
                        end else begin
                           em_region_in = REGION_FLOOR;
                           em_color_in  = floor_ff;
                        end
                        row_in = row_ff + 1'b1;
                        if (last_row) begin
                           active_in = 1'b0;
                        end
                        state_in = B_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         B_FRAC: begin
            prod_in   = cur_ff.perp_dist * dir32;
            div_start = 1'b1;
            state_in  = B_DIV_H;
         end
         B_DIV_H: begin
            tcol_in = tx;
            if (div_done) begin
               if ({1'b0, half_h} > NUM_BITS'(half_s)) begin
                  sstart_in = '0;
                  offset_in = half_h - (NUM_BITS-1)'(half_s);
               end else begin
                  sstart_in = half_s - ROW_BITS'(half_h);
                  offset_in = '0;
               end
               send_in   = (end_sum >= NUM_BITS'(h_eff)) ? ROW_BITS'(h_eff - 1'b1)
                                                         : ROW_BITS'(end_sum);
               hzero_in  = (height == '0);
               div_start = 1'b1;
               div_num   = NUM_BITS'(TEX_SIZE) << 16;
               div_den   = 32'(height);
               state_in  = B_DIV_S;
            end
         end
         B_DIV_S: begin
            if (div_done) begin
               tstep_in = hzero_ff ? '1 : 32'(div_quo);
               state_in = B_POS;
            end
         end
         B_POS: begin
            tpos_in   = 32'(offset_ff * tstep_ff);
            row_in    = '0;
            active_in = 1'b1;
            col_in    = cur_ff.column;
            state_in  = B_IDLE;
         end
         B_EMIT: begin
            // texture position moves on only once the sample has left, so the
            // read address holds while the output is stalled
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = em_addr_ff;
               rsp_color_in  = (em_region_ff == REGION_WALL) ? ram_rdata : em_color_ff;
               rsp_region_in = em_region_ff;
               rsp_last_in   = em_last_ff;
               if (em_region_ff == REGION_WALL) begin
                  tpos_in = tpos_ff + tstep_ff;
               end
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         row_ff       <= '0;
         active_ff    <= 1'b0;
         col_ff       <= '0;
         sstart_ff    <= '0;
         send_ff      <= '0;
         tcol_ff      <= '0;
         tpos_ff      <= '0;
         tstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sh_ff        <= SH_BITS'(480);
         sw_ff        <= SW_BITS'(640);
         ceil_ff      <= '0;
         floor_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         active_ff    <= active_in;
         col_ff       <= col_in;
         sstart_ff    <= sstart_in;
         send_ff      <= send_in;
         tcol_ff      <= tcol_in;
         tpos_ff      <= tpos_in;
         tstep_ff     <= tstep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_SCREEN_HEIGHT: sh_ff    <= csr_data[SH_BITS-1:0];
               CSR_SCREEN_WIDTH:  sw_ff    <= csr_data[SW_BITS-1:0];
               CSR_CEILING_COLOR: ceil_ff  <= csr_data;
               CSR_FLOOR_COLOR:   floor_ff <= csr_data;
               default: ;
            endcase
         end
      end
      cur_ff        <= cur_in;
      prod_ff       <= prod_in;
      offset_ff     <= offset_in;
      hzero_ff      <= hzero_in;
      em_addr_ff    <= em_addr_in;
      em_color_ff   <= em_color_in;
      em_region_ff  <= em_region_in;
      em_last_ff    <= em_last_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_region_ff <= rsp_region_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_color  = rsp_color_ff;
   assign rsp_region = rsp_region_ff;
   assign rsp_last   = rsp_last_ff;

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT && rsp_valid_ff && !rsp_ready) |=> state_ff == B_EMIT)
      else $error("pending pixel dropped while output stalled");

   a_slice_order: assert property (@(posedge clock) disable iff (reset)
      sstart_ff <= send_ff)
      else $error("wall slice starts below its end");

   a_column_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> ($past(state_ff) == B_IDLE && $past(last_row)))
      else $error("column ended without a bottom row");

endmodule
`default_nettype wire

### src/textured_wall_column_renderer.sv
// top level of the textured wall column renderer
// A load request writes one texel. A start request runs the fraction, height
// division, step division and position states: the wall height and the texture
// step come from one shared radix-2 divider that produces one quotient bit per
// cycle. A row request gives one pixel from the registered texture read, and no
// request is taken until it is in the output register. A two-entry request queue
// sits in front of the back end, and the output register holds a finished pixel
// while the next request is taken. Configuration writes are always accepted.
`default_nettype none
module textured_wall_column_renderer import rcw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // texel_index, texel_value, column, perp_dist, hit_side, ray_dir_x,
   // ray_dir_y, pos_x, pos_y, zero pad
   input  wire logic [191:0] req_tdata,
   // op
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pixel_address, pixel_color, zero pad
   output logic [55:0]       rsp_tdata,
   // region
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic               q_valid;
   item_type           q_item;
   logic               q_pop;
   logic [PA_BITS-1:0] pix_addr;
   logic [31:0]        pix_color;

   rcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_addr   (pix_addr),
      .rsp_color  (pix_color),
      .rsp_region (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b0, pix_color, pix_addr};

endmodule
`default_nettype wire
